// File: hw/rtl/vrc_pkg.sv
`timescale 1ns / 1ps

package vrc_pkg;

  localparam int MAX_ROUTES = 1024;
  localparam int ORIGIN_BITS = 12;

  // route count stops here, the result field is 11 bits wide
  localparam logic [10:0] ROUTE_LIMIT = (MAX_ROUTES > 2047) ? 11'd2047 : 11'(MAX_ROUTES);

  localparam int IN_DATA_BITS = 160;
  localparam int IN_USER_BITS = 2;
  localparam int OUT_DATA_BITS = 200;

  typedef enum logic [1:0] {
    REG_VEHICLE_CAPACITY = 2'd0,
    REG_DEPOT_LATEST     = 2'd1,
    REG_CAPACITY_PENALTY = 2'd2,
    REG_LATENESS_PENALTY = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [23:0]            travel_in;
    logic [23:0]            travel_home;
    logic [ORIGIN_BITS-1:0] origin_id;
    logic [23:0]            window_open;
    logic [23:0]            window_close;
    logic [23:0]            service_time;
    logic [23:0]            demand;
    logic                   route_first;
    logic                   route_last;
    logic                   solution_last;
  } visit_t;

  // state of a route right after its last visit, before the return leg
  typedef struct packed {
    logic        sol;
    logic [23:0] home;
    logic [31:0] clock;
    logic [31:0] length;
    logic [31:0] load;
    logic [31:0] lateness;
  } route_ev_t;

  typedef struct packed {
    logic        sol;
    logic [31:0] length;
    logic [31:0] load_ex;
    logic [31:0] lateness;
    logic [31:0] late_depot;
  } close_ev_t;

  typedef struct packed {
    logic [39:0] distance;
    logic [10:0] routes;
    logic [39:0] cap_ex;
    logic [39:0] time_ex;
    logic        feasible;
  } total_t;

  typedef struct packed {
    logic [39:0] total_distance;
    logic [10:0] route_count;
    logic [39:0] capacity_excess;
    logic [39:0] time_excess;
    logic [62:0] penalized_cost;
    logic        feasible;
  } result_t;

  function automatic logic [31:0] add_sat32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [39:0] add_sat40(input logic [39:0] a, input logic [39:0] b);
    logic [40:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[40] ? 40'hFF_FFFF_FFFF : s[39:0];
  endfunction

endpackage

// File: hw/rtl/vrptw_route_cost_evaluator_top.sv
`timescale 1ns / 1ps

// Route cost evaluator for vehicle routing with time windows.
// s_* carries one visit per transfer in route order; s_tlast marks the last
// visit of a route, s_tuser marks route start and solution end. m_* carries
// one result per solution: distance, route count, capacity and time excess,
// penalized cost and a feasibility flag.
// cfg_* writes the four registers (capacity, depot latest, two penalty
// weights); cfg_ready is always high, writes belong to idle periods.
// Throughput: one visit per cycle while s_tready is high. The route clock, length,
// load and lateness registers update once per visit, which sets that rate.
// The result appears on m_tvalid after the visit that ends the solution has
// passed the input register, visit update, return leg, solution sums, multiply
// and cost add.
// Reset clears all route and solution state and loads the register defaults.
// A stalled m_tready holds the result; visits keep flowing while the multiply
// stage can still take a result, and s_tready drops once a third solution end
// reaches the sums stage behind the two waiting results, until m_tready frees
// the output register.
module vrptw_route_cost_evaluator_top (
  input  logic                              clk,
  input  logic                              rst,
  // travel_in, travel_home, origin_id, window_open, window_close, service_time, demand
  input  logic [vrc_pkg::IN_DATA_BITS-1:0]  s_tdata,
  // route_first, solution_last
  input  logic [vrc_pkg::IN_USER_BITS-1:0]  s_tuser,
  input  logic                              s_tlast,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // total_distance, route_count, capacity_excess, time_excess, penalized_cost, feasible
  output logic [vrc_pkg::OUT_DATA_BITS-1:0] m_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [31:0]                       cfg_data
);

  logic [31:0] vehicle_capacity;
  logic [23:0] depot_latest;
  logic [15:0] capacity_penalty;
  logic [15:0] lateness_penalty;

  vrc_pkg::visit_t    item;
  vrc_pkg::route_ev_t ev;
  vrc_pkg::total_t    tot;
  vrc_pkg::result_t   result;
  logic               ev_valid, front_ready, tot_valid, tot_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vehicle_capacity <= 32'd0;
      depot_latest     <= 24'hFF_FFFF;
      capacity_penalty <= 16'd256;
      lateness_penalty <= 16'd256;
    end else if (cfg_valid && cfg_ready) begin
      case (vrc_pkg::cfg_reg_t'(cfg_index))
        vrc_pkg::REG_VEHICLE_CAPACITY: vehicle_capacity <= cfg_data;
        vrc_pkg::REG_DEPOT_LATEST:     depot_latest     <= cfg_data[23:0];
        vrc_pkg::REG_CAPACITY_PENALTY: capacity_penalty <= cfg_data[15:0];
        vrc_pkg::REG_LATENESS_PENALTY: lateness_penalty <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    item.travel_in     = s_tdata[23:0];
    item.travel_home   = s_tdata[47:24];
    item.origin_id     = s_tdata[59:48];
    item.window_open   = s_tdata[83:60];
    item.window_close  = s_tdata[107:84];
    item.service_time  = s_tdata[131:108];
    item.demand        = s_tdata[155:132];
    item.route_first   = s_tuser[0];
    item.route_last    = s_tlast;
    item.solution_last = s_tuser[1];
  end

  assign s_tready = front_ready;

  vrc_visit u_visit (
    .clk      (clk),
    .rst      (rst),
    .advance  (front_ready),
    .take     (s_tvalid),
    .item     (item),
    .ev_valid (ev_valid),
    .ev       (ev)
  );

  vrc_close u_close (
    .clk              (clk),
    .rst              (rst),
    .ev_valid         (ev_valid),
    .ev               (ev),
    .vehicle_capacity (vehicle_capacity),
    .depot_latest     (depot_latest),
    .tot_ready        (tot_ready),
    .front_ready      (front_ready),
    .tot_valid        (tot_valid),
    .tot              (tot)
  );

  vrc_cost u_cost (
    .clk              (clk),
    .rst              (rst),
    .tot_valid        (tot_valid),
    .tot              (tot),
    .capacity_penalty (capacity_penalty),
    .lateness_penalty (lateness_penalty),
    .tot_ready        (tot_ready),
    .out_ready        (m_tready),
    .out_valid        (m_tvalid),
    .out_q            (result)
  );

  assign m_tdata = {5'd0, result.feasible, result.penalized_cost, result.time_excess,
                    result.capacity_excess, result.route_count, result.total_distance};

endmodule

// File: hw/rtl/vrc_visit.sv
`timescale 1ns / 1ps

module vrc_visit (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic               take,
  input  vrc_pkg::visit_t    item,
  output logic               ev_valid,
  output vrc_pkg::route_ev_t ev
);

  logic                            in_valid;
  vrc_pkg::visit_t                 in_q;

  logic [31:0]                     clock_now;
  logic [31:0]                     route_length;
  logic [31:0]                     route_load;
  logic [31:0]                     route_lateness;
  logic [vrc_pkg::ORIGIN_BITS-1:0] previous_origin;
  logic                            route_open;

  logic [31:0] base_clock, base_length, base_load, base_lateness;
  logic [31:0] arrive, start, late_add;
  logic [31:0] clock_next, length_next, load_next, lateness_next;
  logic        split, early, close;

  always_comb begin
    base_clock    = in_q.route_first ? 32'd0 : clock_now;
    base_length   = in_q.route_first ? 32'd0 : route_length;
    base_load     = in_q.route_first ? 32'd0 : route_load;
    base_lateness = in_q.route_first ? 32'd0 : route_lateness;
    split = route_open && !in_q.route_first && (in_q.origin_id == previous_origin);

    arrive = vrc_pkg::add_sat32(base_clock, {8'd0, in_q.travel_in});
    early  = arrive < {8'd0, in_q.window_open};
    start  = early ? {8'd0, in_q.window_open} : arrive;
    // lateness only counts when the vehicle did not have to wait
    late_add = (!early && arrive > {8'd0, in_q.window_close}) ?
               arrive - {8'd0, in_q.window_close} : 32'd0;

    if (split) begin
      clock_next    = base_clock;
      length_next   = base_length;
      lateness_next = base_lateness;
    end else begin
      clock_next    = vrc_pkg::add_sat32(start, {8'd0, in_q.service_time});
      length_next   = vrc_pkg::add_sat32(base_length, {8'd0, in_q.travel_in});
      lateness_next = vrc_pkg::add_sat32(base_lateness, late_add);
    end
    load_next = vrc_pkg::add_sat32(base_load, {8'd0, in_q.demand});
    close = in_q.route_last || in_q.solution_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid        <= 1'b0;
      ev_valid        <= 1'b0;
      route_open      <= 1'b0;
      clock_now       <= '0;
      route_length    <= '0;
      route_load      <= '0;
      route_lateness  <= '0;
      previous_origin <= '0;
    end else if (advance) begin
      in_valid <= take;
      ev_valid <= in_valid && close;
      if (in_valid) begin
        if (close) begin
          route_open      <= 1'b0;
          clock_now       <= '0;
          route_length    <= '0;
          route_load      <= '0;
          route_lateness  <= '0;
          previous_origin <= '0;
        end else begin
          route_open      <= 1'b1;
          clock_now       <= clock_next;
          route_length    <= length_next;
          route_load      <= load_next;
          route_lateness  <= lateness_next;
          previous_origin <= in_q.origin_id;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (take) begin
        in_q <= item;
      end
      ev.sol      <= in_q.solution_last;
      ev.home     <= in_q.travel_home;
      ev.clock    <= clock_next;
      ev.length   <= length_next;
      ev.load     <= load_next;
      ev.lateness <= lateness_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    !route_open |-> (clock_now == 32'd0 && route_load == 32'd0 && route_lateness == 32'd0))
    else $error("closed route left state behind");

  assert property (@(posedge clk) disable iff (rst)
    (advance && in_valid && close) |=> !route_open)
    else $error("route still open after its last visit");

endmodule

// File: hw/rtl/vrc_close.sv
`timescale 1ns / 1ps

module vrc_close (
  input  logic               clk,
  input  logic               rst,
  input  logic               ev_valid,
  input  vrc_pkg::route_ev_t ev,
  input  logic [31:0]        vehicle_capacity,
  input  logic [23:0]        depot_latest,
  input  logic               tot_ready,
  output logic               front_ready,
  output logic               tot_valid,
  output vrc_pkg::total_t    tot
);

  logic               ev2_valid;
  vrc_pkg::close_ev_t ev2;

  logic [39:0] sum_distance, sum_capacity_excess, sum_lateness;
  logic [10:0] sum_routes;

  logic [31:0] clock_home, late_depot, length_home, load_ex, route_late;
  logic [39:0] dist_next, cap_next, late_next;
  logic [10:0] routes_next;

  // return leg and excesses of the closing route
  always_comb begin
    clock_home  = vrc_pkg::add_sat32(ev.clock, {8'd0, ev.home});
    length_home = vrc_pkg::add_sat32(ev.length, {8'd0, ev.home});
    late_depot  = (clock_home > {8'd0, depot_latest}) ?
                  clock_home - {8'd0, depot_latest} : 32'd0;
    load_ex     = (ev.load > vehicle_capacity) ? ev.load - vehicle_capacity : 32'd0;
  end

  // solution sums including the route in ev2
  always_comb begin
    route_late  = vrc_pkg::add_sat32(ev2.lateness, ev2.late_depot);
    dist_next   = vrc_pkg::add_sat40(sum_distance, {8'd0, ev2.length});
    cap_next    = vrc_pkg::add_sat40(sum_capacity_excess, {8'd0, ev2.load_ex});
    late_next   = vrc_pkg::add_sat40(sum_lateness, {8'd0, route_late});
    routes_next = (sum_routes < vrc_pkg::ROUTE_LIMIT) ? sum_routes + 11'd1 : sum_routes;

    tot.distance = dist_next;
    tot.routes   = routes_next;
    tot.cap_ex   = cap_next;
    tot.time_ex  = late_next;
    tot.feasible = (cap_next == 40'd0) && (late_next == 40'd0);

    tot_valid   = ev2_valid && ev2.sol;
    front_ready = !tot_valid || tot_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ev2_valid           <= 1'b0;
      sum_distance        <= '0;
      sum_routes          <= '0;
      sum_capacity_excess <= '0;
      sum_lateness        <= '0;
    end else if (front_ready) begin
      ev2_valid <= ev_valid;
      if (ev2_valid) begin
        if (ev2.sol) begin
          sum_distance        <= '0;
          sum_routes          <= '0;
          sum_capacity_excess <= '0;
          sum_lateness        <= '0;
        end else begin
          sum_distance        <= dist_next;
          sum_routes          <= routes_next;
          sum_capacity_excess <= cap_next;
          sum_lateness        <= late_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (front_ready && ev_valid) begin
      ev2.sol        <= ev.sol;
      ev2.length     <= length_home;
      ev2.load_ex    <= load_ex;
      ev2.lateness   <= ev.lateness;
      ev2.late_depot <= late_depot;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    sum_routes <= vrc_pkg::ROUTE_LIMIT)
    else $error("route count past its limit");

endmodule

// File: hw/rtl/vrc_cost.sv
`timescale 1ns / 1ps

module vrc_cost (
  input  logic             clk,
  input  logic             rst,
  input  logic             tot_valid,
  input  vrc_pkg::total_t  tot,
  input  logic [15:0]      capacity_penalty,
  input  logic [15:0]      lateness_penalty,
  output logic             tot_ready,
  input  logic             out_ready,
  output logic             out_valid,
  output vrc_pkg::result_t out_q
);

  logic            mul_valid;
  vrc_pkg::total_t tot_q;
  logic [55:0]     prod_cap, prod_late;
  logic [62:0]     cost;
  logic            out_free;

  // three terms stay below 2**58, so the 63-bit sum cannot overflow
  always_comb begin
    out_free  = !out_valid || out_ready;
    tot_ready = !mul_valid || out_free;
    cost = {15'd0, tot_q.distance, 8'd0} + {7'd0, prod_cap} + {7'd0, prod_late};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (tot_ready) begin
        mul_valid <= tot_valid;
      end
      if (out_free) begin
        out_valid <= mul_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tot_ready && tot_valid) begin
      tot_q     <= tot;
      prod_cap  <= tot.cap_ex * capacity_penalty;
      prod_late <= tot.time_ex * lateness_penalty;
    end
    if (out_free && mul_valid) begin
      out_q.total_distance  <= tot_q.distance;
      out_q.route_count     <= tot_q.routes;
      out_q.capacity_excess <= tot_q.cap_ex;
      out_q.time_excess     <= tot_q.time_ex;
      out_q.penalized_cost  <= cost;
      out_q.feasible        <= tot_q.feasible;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_q.penalized_cost >= {15'd0, out_q.total_distance, 8'd0}))
    else $error("penalized cost below distance");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_q.feasible ==
                   (out_q.capacity_excess == 40'd0 && out_q.time_excess == 40'd0)))
    else $error("feasible flag disagrees with excesses");

endmodule
